// ----- rtl/core/ttd_pkg.sv -----
// tiled texel detiler package: format codes, register indexes, lane masks
// item and result structs, texel expansion functions; no dependencies
`default_nettype none

package ttd_pkg;

    localparam int COORD_W = 12;
    localparam int DIM_W   = 11;
    localparam int IDX_W   = 20;

    localparam logic [2:0] FMT_I4     = 3'd0;
    localparam logic [2:0] FMT_I8     = 3'd1;
    localparam logic [2:0] FMT_A4I4   = 3'd2;
    localparam logic [2:0] FMT_A8I8   = 3'd3;
    localparam logic [2:0] FMT_R5G6B5 = 3'd4;
    localparam logic [2:0] FMT_RGB5A3 = 3'd5;
    localparam logic [2:0] FMT_ARGB8  = 3'd6;
    localparam logic [2:0] FMT_NONE   = 3'd7;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [3:0] LANE_NONE = 4'd0;
    localparam logic [3:0] LANE_BYTE = 4'd1;
    localparam logic [3:0] LANE_WORD = 4'd3;
    localparam logic [3:0] LANE_RGBA = 4'd15;
    localparam logic [3:0] LANE_AR   = 4'd9;
    localparam logic [3:0] LANE_GB   = 4'd6;

    localparam logic [DIM_W-1:0] RESET_DIM = 11'd1024;

    typedef struct packed {
        logic [15:0]        src;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [2:0]         fmt;
        logic               gb;
        logic               done;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic [31:0]      texel;
        logic [3:0]       lane_mask;
        logic             run_end;
        logic             image_end;
    } t_res;

    function automatic logic [7:0] rep4(input logic [3:0] n);
        return {n, n};
    endfunction

    function automatic logic [7:0] rep5(input logic [4:0] n);
        return {n, n[4:2]};
    endfunction

    function automatic logic [31:0] rgb5a3_expand(input logic [15:0] p);
        logic [7:0] r, g, b, a;
        if (p[15]) begin
            a = 8'hff;
            r = rep5(p[14:10]);
            g = rep5(p[9:5]);
            b = rep5(p[4:0]);
        end else begin
            a = {p[14:12], p[14:12], p[14:13]};
            r = rep4(p[11:8]);
            g = rep4(p[7:4]);
            b = rep4(p[3:0]);
        end
        return {a, b, g, r};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ttd_walk.sv -----
// tile walk counters and the input register of the detiler
// depends on ttd_pkg
`default_nettype none

module ttd_walk #(
    parameter int MAX_DIM = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_restart,
    input  wire  [2:0]          i_fmt,
    input  wire  [10:0]         i_width,
    input  wire  [10:0]         i_height,
    input  wire                 i_valid,
    input  wire  [15:0]         i_src_unit,
    output logic                o_stall,
    input  wire                 i_take,
    output ttd_pkg::t_item      o_item,
    output logic                o_item_vld
);
    import ttd_pkg::*;

    localparam int CMP_W = $clog2(MAX_DIM + 1) + DIM_W;

    logic [DIM_W-1:0]   r_tile_x, r_tile_y;
    logic [2:0]         r_row, r_col;
    logic               r_gb;
    logic               r_vld;
    t_item              r_item;

    logic [DIM_W-1:0]   n_tile_x, n_tile_y;
    logic [2:0]         n_row, n_col;
    logic               n_gb;
    logic               n_done;
    logic               load;
    logic [DIM_W-1:0]   w_c, h_c;
    logic [3:0]         tw, th, step, col_n, row_n;
    logic [COORD_W-1:0] tx_n, ty_n;

    always_comb begin
        w_c = (CMP_W'(i_width) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_width;
        h_c = (CMP_W'(i_height) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_height;
        tw   = (i_fmt <= FMT_A4I4) ? 4'd8 : 4'd4;
        th   = (i_fmt == FMT_I4) ? 4'd8 : 4'd4;
        step = (i_fmt == FMT_I4) ? 4'd2 : 4'd1;
        col_n = {1'b0, r_col} + step;
        row_n = {1'b0, r_row} + 4'd1;
        tx_n  = {1'b0, r_tile_x} + COORD_W'(tw);
        ty_n  = {1'b0, r_tile_y} + COORD_W'(th);

        n_tile_x = r_tile_x;
        n_tile_y = r_tile_y;
        n_row    = r_row;
        n_col    = col_n[2:0];
        n_gb     = r_gb;
        n_done   = 1'b0;
        if (col_n >= tw) begin
            n_col = 3'd0;
            n_row = row_n[2:0];
            if (row_n >= th) begin
                n_row = 3'd0;
                if (i_fmt == FMT_ARGB8 && !r_gb) begin
                    n_gb = 1'b1;
                end else begin
                    n_gb     = 1'b0;
                    n_tile_x = tx_n[DIM_W-1:0];
                    if (tx_n >= {1'b0, w_c}) begin
                        n_tile_x = '0;
                        n_tile_y = ty_n[DIM_W-1:0];
                        if (ty_n >= {1'b0, h_c}) begin
                            n_tile_y = '0;
                            n_done   = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_stall = r_vld && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_tile_x <= '0;
            r_tile_y <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_gb     <= 1'b0;
        end else if (load && i_fmt != FMT_NONE) begin
            r_tile_x <= n_tile_x;
            r_tile_y <= n_tile_y;
            r_row    <= n_row;
            r_col    <= n_col;
            r_gb     <= n_gb;
        end
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
        if (load) begin
            r_item.src  <= i_src_unit;
            r_item.x    <= {1'b0, r_tile_x} + COORD_W'(r_col);
            r_item.y    <= {1'b0, r_tile_y} + COORD_W'(r_row);
            r_item.fmt  <= i_fmt;
            r_item.gb   <= r_gb;
            r_item.done <= n_done;
            r_item.w    <= w_c;
            r_item.h    <= h_c;
        end
    end

    assign o_item     = r_item;
    assign o_item_vld = r_vld;

endmodule

`default_nettype wire

// ----- rtl/core/ttd_decode.sv -----
// texel decode: destination index and up to two results for one source unit
// depends on ttd_pkg
`default_nettype none

module ttd_decode (
    input  ttd_pkg::t_item i_item,
    input  wire            i_item_vld,
    output ttd_pkg::t_res  o_res0,
    output ttd_pkg::t_res  o_res1,
    output logic [1:0]     o_count
);
    import ttd_pkg::*;

    logic [22:0]      prod;
    logic [IDX_W-1:0] idx;
    logic             y_in, a_ok, b_ok;
    logic [31:0]      tex_a, tex_b;
    logic [3:0]       lane_a;
    t_res             ra, rb;

    always_comb begin
        prod = 23'(i_item.y) * 23'({1'b0, i_item.w}) + 23'(i_item.x);
        idx  = prod[IDX_W-1:0];
        y_in = i_item.y < {1'b0, i_item.h};
        a_ok = i_item_vld && y_in && (i_item.x < {1'b0, i_item.w})
               && i_item.fmt != FMT_NONE;
        b_ok = i_item_vld && y_in && i_item.fmt == FMT_I4
               && ((i_item.x + 12'd1) < {1'b0, i_item.w});
        tex_b  = {24'd0, rep4(i_item.src[3:0])};
        tex_a  = {16'd0, i_item.src};
        lane_a = LANE_WORD;
        case (i_item.fmt)
            FMT_I4: begin
                tex_a  = {24'd0, rep4(i_item.src[7:4])};
                lane_a = LANE_BYTE;
            end
            FMT_I8, FMT_A4I4: begin
                tex_a  = {24'd0, i_item.src[7:0]};
                lane_a = LANE_BYTE;
            end
            FMT_RGB5A3: begin
                tex_a  = rgb5a3_expand(i_item.src);
                lane_a = LANE_RGBA;
            end
            FMT_ARGB8: begin
                if (!i_item.gb) begin
                    tex_a  = {i_item.src[15:8], 16'd0, i_item.src[7:0]};
                    lane_a = LANE_AR;
                end else begin
                    tex_a  = {8'd0, i_item.src[7:0], i_item.src[15:8], 8'd0};
                    lane_a = LANE_GB;
                end
            end
            default: begin
                tex_a  = {16'd0, i_item.src};
                lane_a = LANE_WORD;
            end
        endcase

        ra = '{dest_index: idx, texel: tex_a, lane_mask: lane_a,
               run_end: !b_ok, image_end: i_item.done};
        rb = '{dest_index: idx + 20'd1, texel: tex_b, lane_mask: LANE_BYTE,
               run_end: 1'b1, image_end: i_item.done};

        o_res1  = rb;
        o_count = 2'd0;
        if (a_ok && b_ok) begin
            o_res0  = ra;
            o_count = 2'd2;
        end else if (a_ok) begin
            o_res0  = ra;
            o_count = 2'd1;
        end else if (b_ok) begin
            o_res0  = rb;
            o_count = 2'd1;
        end else begin
            o_res0 = '{dest_index: '0, texel: '0, lane_mask: LANE_NONE,
                       run_end: 1'b1, image_end: 1'b1};
            if (i_item_vld && i_item.done && i_item.fmt != FMT_NONE) begin
                o_count = 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ttd_outq.sv -----
// four-entry result queue, takes up to two results per cycle and gives one per cycle unless stalled
// depends on ttd_pkg
`default_nettype none

module ttd_outq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire  [1:0]     i_count,
    input  ttd_pkg::t_res  i_res0,
    input  ttd_pkg::t_res  i_res1,
    output logic           o_room,
    output logic           o_valid,
    input  wire            i_stall,
    output ttd_pkg::t_res  o_res
);
    import ttd_pkg::*;

    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] n_add;
    logic       pop;

    assign o_room  = r_cnt <= 3'd2;
    assign o_valid = r_cnt != 3'd0;
    assign pop     = o_valid && !i_stall;
    assign n_add   = i_push ? i_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_add;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, n_add} - {2'b0, pop};
        end
        if (n_add != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (n_add == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res1;
        end
    end

    assign o_res = r_mem[r_rp];

endmodule

`default_nettype wire

// ----- rtl/core/tiled_texel_detiler.sv -----
// tiled texel detiler top level: register port, walk, decode, result queue
// input is registered in the walk, decoded, and queued in a four-entry result queue; one
// source unit per cycle unless o_stall, results leave one per cycle unless i_stall, so I4
// (two texels per byte) can stall the input; the y*width multiply sets the path
// synchronous active-low reset: walk at the first tile, queue empty,
// format I4, width and height 1024
`default_nettype none

module tiled_texel_detiler #(
    parameter int MAX_DIM = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_src_unit,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [19:0] o_dest_index,
    output logic [31:0] o_texel,
    output logic [3:0]  o_lane_mask,
    output logic        o_run_end,
    output logic        o_image_end
);
    import ttd_pkg::*;

    logic [2:0]       r_fmt;
    logic [DIM_W-1:0] r_width, r_height;
    logic             wr, restart, take, room;
    logic [1:0]       cnt;
    t_item            item;
    logic             item_vld;
    t_res             res0, res1, res;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign restart = wr && (paddr[3:2] inside {REG_FORMAT, REG_WIDTH, REG_HEIGHT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_I4;
            r_width  <= RESET_DIM;
            r_height <= RESET_DIM;
        end else if (wr) begin
            case (paddr[3:2])
                REG_FORMAT: r_fmt    <= pwdata[2:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT: prdata = {29'd0, r_fmt};
            REG_WIDTH:  prdata = {21'd0, r_width};
            REG_HEIGHT: prdata = {21'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    assign take = room;

    ttd_walk #(.MAX_DIM(MAX_DIM)) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_fmt      (r_fmt),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_valid    (i_valid),
        .i_src_unit (i_src_unit),
        .o_stall    (o_stall),
        .i_take     (take),
        .o_item     (item),
        .o_item_vld (item_vld)
    );

    ttd_decode u_decode (
        .i_item     (item),
        .i_item_vld (item_vld),
        .o_res0     (res0),
        .o_res1     (res1),
        .o_count    (cnt)
    );

    ttd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_vld && room),
        .i_count (cnt),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_dest_index = res.dest_index;
    assign o_texel      = res.texel;
    assign o_lane_mask  = res.lane_mask;
    assign o_run_end    = res.run_end;
    assign o_image_end  = res.image_end;

endmodule

`default_nettype wire

// ----- rtl/core/ttd_check.sv -----
// port-level checks for the tiled texel detiler and their bind
// depends on tiled_texel_detiler
`default_nettype none

module ttd_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_stall,
    input wire [19:0] o_dest_index,
    input wire [31:0] o_texel,
    input wire [3:0]  o_lane_mask,
    input wire        o_run_end,
    input wire        o_image_end
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_index) && $stable(o_texel)
            && $stable(o_lane_mask) && $stable(o_run_end) && $stable(o_image_end))
        else $error("stalled result changed");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lane_mask == 4'd0 |->
            o_run_end && o_image_end && o_dest_index == 20'd0 && o_texel == 32'd0)
        else $error("bad end marker");

    a_gb_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lane_mask == 4'd6 |-> o_texel[7:0] == 8'd0 && o_texel[31:24] == 8'd0)
        else $error("gb pass touches ar bytes");

    a_byte_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lane_mask == 4'd1 |-> o_texel[31:8] == 24'd0)
        else $error("byte texel has upper bits set");

endmodule

bind tiled_texel_detiler ttd_check u_check (.*);

`default_nettype wire

// ----- tb/sv/tb_tiled_texel_detiler.sv -----
// testbench for tiled_texel_detiler: a directed table then random image phases, each result
// checked against a tile-walk predictor or a typed table row; needs ttd_pkg and tiled_texel_detiler only
`default_nettype none

module tb_tiled_texel_detiler;
    timeunit 1ns;
    timeprecision 1ps;

    import ttd_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int RANDOM_UNITS = 1300;
    localparam int SETTLE       = 8;
    localparam int IDLE_PCT     = 5;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam t_res       NO_RES    = '0;

    typedef enum logic [1:0] {ROW_WRITE, ROW_UNIT, ROW_CHECKED} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] data;
        logic [15:0] src;
        logic [1:0]  n_typed;
        t_res        r0;
        t_res        r1;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [3:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    logic [15:0] i_src_unit = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    logic [19:0] o_dest_index;
    logic [31:0] o_texel;
    logic [3:0]  o_lane_mask;
    logic        o_run_end;
    logic        o_image_end;

    // predictor copy of registers and walk position
    logic [2:0]  cur_fmt;
    logic [10:0] cur_w;
    logic [10:0] cur_h;
    logic [11:0] org_x;
    logic [11:0] org_y;
    logic [3:0]  sub_row;
    logic [3:0]  sub_col;
    logic        second_pass;

    t_res        pending [$];
    t_row        script [$];
    t_res        head;
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    logic        calm    = 1'b0;

    tiled_texel_detiler #(.MAX_DIM(MAX_DIM)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_src_unit   (i_src_unit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_dest_index (o_dest_index),
        .o_texel      (o_texel),
        .o_lane_mask  (o_lane_mask),
        .o_run_end    (o_run_end),
        .o_image_end  (o_image_end)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_res texel_res(input logic [19:0] idx, input logic [31:0] px,
                                       input logic [3:0] lane, input logic re,
                                       input logic ie);
        t_res r;
        r.dest_index = idx;
        r.texel      = px;
        r.lane_mask  = lane;
        r.run_end    = re;
        r.image_end  = ie;
        return r;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] c);
        return (8'(c) << 3) | (8'(c) >> 2);
    endfunction

    function automatic void restart_walk();
        org_x       = '0;
        org_y       = '0;
        sub_row     = '0;
        sub_col     = '0;
        second_pass = 1'b0;
    endfunction

    function automatic void walk_and_decode(input logic [15:0] src);
        logic [10:0] w;
        logic [10:0] h;
        logic [3:0]  tw;
        logic [3:0]  th;
        logic [3:0]  stride;
        logic [11:0] x;
        logic [11:0] y;
        logic [19:0] idx;
        logic [2:0]  a3;
        logic [31:0] px;
        logic [3:0]  lane;
        logic        done;
        t_res        got [2];
        int          n;
        if (cur_fmt == FMT_NONE) return;
        w = (cur_w > MAX_DIM) ? 11'(MAX_DIM) : cur_w;
        h = (cur_h > MAX_DIM) ? 11'(MAX_DIM) : cur_h;
        tw = (cur_fmt == FMT_I4 || cur_fmt == FMT_I8 || cur_fmt == FMT_A4I4) ? 4'd8 : 4'd4;
        th = (cur_fmt == FMT_I4) ? 4'd8 : 4'd4;
        stride = (cur_fmt == FMT_I4) ? 4'd2 : 4'd1;
        x = org_x + 12'(sub_col);
        y = org_y + 12'(sub_row);
        idx = y * w + x;
        n = 0;
        done = 1'b0;
        px = '0;
        lane = LANE_NONE;
        if (y < h) begin
            if (cur_fmt == FMT_I4) begin
                if (x < w) begin
                    got[n] = texel_res(idx, 32'(src[7:4]) * 17, LANE_BYTE, 1'b0, 1'b0);
                    n++;
                end
                if (x + 1 < w) begin
                    got[n] = texel_res(idx + 20'd1, 32'(src[3:0]) * 17, LANE_BYTE,
                                       1'b0, 1'b0);
                    n++;
                end
            end else if (x < w) begin
                case (cur_fmt)
                    FMT_I8, FMT_A4I4: begin
                        px = {24'd0, src[7:0]};
                        lane = LANE_BYTE;
                    end
                    FMT_A8I8, FMT_R5G6B5: begin
                        px = {16'd0, src};
                        lane = LANE_WORD;
                    end
                    FMT_RGB5A3: begin
                        lane = LANE_RGBA;
                        if (src[15]) begin
                            px = {8'hff, widen5(src[4:0]), widen5(src[9:5]), widen5(src[14:10])};
                        end else begin
                            a3 = src[14:12];
                            px = {a3, a3, a3[2:1], 8'(src[3:0]) * 8'd17,
                                  8'(src[7:4]) * 8'd17, 8'(src[11:8]) * 8'd17};
                        end
                    end
                    default: begin
                        if (second_pass) begin
                            px = {8'd0, src[7:0], src[15:8], 8'd0};
                            lane = LANE_GB;
                        end else begin
                            px = {src[15:8], 16'd0, src[7:0]};
                            lane = LANE_AR;
                        end
                    end
                endcase
                got[n] = texel_res(idx, px, lane, 1'b0, 1'b0);
                n++;
            end
        end
        sub_col = sub_col + stride;
        if (sub_col >= tw) begin
            sub_col = '0;
            sub_row = sub_row + 4'd1;
            if (sub_row >= th) begin
                sub_row = '0;
                if (cur_fmt == FMT_ARGB8 && !second_pass) begin
                    second_pass = 1'b1;
                end else begin
                    second_pass = 1'b0;
                    org_x = org_x + 12'(tw);
                    if (org_x >= w) begin
                        org_x = '0;
                        org_y = org_y + 12'(th);
                        if (org_y >= h) begin
                            org_y = '0;
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        // completing transfer with no texel yields an empty marker
        if (done && n == 0) begin
            got[0] = texel_res('0, '0, LANE_NONE, 1'b0, 1'b0);
            n = 1;
        end
        for (int k = 0; k < n; k++) begin
            got[k].run_end = (k == n - 1);
            got[k].image_end = done;
            pending = {pending, got[k]};
        end
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [31:0] val);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.data = val;
        script = {script, r};
    endfunction

    function automatic void add_unit(input logic checked, input logic [15:0] src,
                                     input logic [1:0] n, input t_res r0, input t_res r1);
        t_row r;
        r = '0;
        r.kind = checked ? ROW_CHECKED : ROW_UNIT;
        r.src = src;
        r.n_typed = n;
        r.r0 = r0;
        r.r1 = r1;
        script = {script, r};
    endfunction

    function automatic logic [10:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return 11'd0;
        if (r < 15) return RESET_DIM;
        if (r < 19) return 11'd2047;
        if (r < 23) return 11'($urandom_range(1025, 2046));
        if (r < 30) return 11'($urandom_range(25, 1023));
        return 11'($urandom_range(1, 24));
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FORMAT: begin
                cur_fmt = val[2:0];
                restart_walk();
            end
            REG_WIDTH: begin
                cur_w = val[10:0];
                restart_walk();
            end
            REG_HEIGHT: begin
                cur_h = val[10:0];
                restart_walk();
            end
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_unit(input t_row r);
        int depth;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 20);
        end
        i_valid <= 1'b1;
        i_src_unit <= r.src;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        depth = pending.size();
        walk_and_decode(r.src);
        if (r.kind == ROW_CHECKED) begin
            while (pending.size() > depth) void'(pending.pop_back());
            if (r.n_typed > 0) pending = {pending, r.r0};
            if (r.n_typed > 1) pending = {pending, r.r1};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            err_cnt++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected transfer, expected none actual index %0h texel %0h",
                         $time, o_dest_index, o_texel);
            end else begin
                head = pending.pop_front();
                check_field("dest_index", 32'(head.dest_index), 32'(o_dest_index));
                check_field("texel", head.texel, o_texel);
                check_field("lane_mask", 32'(head.lane_mask), 32'(o_lane_mask));
                check_field("run_end", 32'(head.run_end), 32'(o_run_end));
                check_field("image_end", 32'(head.image_end), 32'(o_image_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int          sent;
        int          n;
        int          units;
        int          tiles_x;
        int          tiles_y;
        int          tw;
        int          th;
        int          cw;
        int          ch;
        logic [2:0]  f;
        logic [10:0] w;
        logic [10:0] h;
        logic        paused;
        t_row        one;

        cur_fmt = FMT_I4;
        cur_w = RESET_DIM;
        cur_h = RESET_DIM;
        restart_walk();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: I4, 1024 x 1024; high byte ignored
        add_unit(1, 16'hff5a, 2, texel_res(0, 32'h55, LANE_BYTE, 0, 0),
                 texel_res(1, 32'haa, LANE_BYTE, 1, 0));
        add_write(REG_FORMAT, {29'd0, FMT_A8I8});
        add_unit(1, 16'hffff, 1, texel_res(0, 32'hffff, LANE_WORD, 1, 0), NO_RES);
        add_unit(1, 16'h0000, 1, texel_res(1, 32'h0, LANE_WORD, 1, 0), NO_RES);
        // oversized dimensions clamp, second texel row starts at 1024
        add_write(REG_FORMAT, {29'd0, FMT_R5G6B5});
        add_write(REG_WIDTH, 32'd2047);
        add_write(REG_HEIGHT, 32'd2047);
        add_unit(0, 16'h1234, 0, NO_RES, NO_RES);
        add_unit(0, 16'hf800, 0, NO_RES, NO_RES);
        add_unit(0, 16'h07e0, 0, NO_RES, NO_RES);
        add_unit(0, 16'h001f, 0, NO_RES, NO_RES);
        add_unit(1, 16'habcd, 1, texel_res(1024, 32'habcd, LANE_WORD, 1, 0), NO_RES);
        // 1 x 1 image: one texel, empty completion marker, then wrap
        add_write(REG_FORMAT, {29'd0, FMT_RGB5A3});
        add_write(REG_WIDTH, 32'd1);
        add_write(REG_HEIGHT, 32'd1);
        add_unit(1, 16'hffff, 1, texel_res(0, 32'hffffffff, LANE_RGBA, 1, 0), NO_RES);
        for (int k = 0; k < 14; k++) add_unit(1, 16'(k * 16'h1249), 0, NO_RES, NO_RES);
        add_unit(1, 16'h1234, 1, texel_res(0, 32'h0, LANE_NONE, 1, 1), NO_RES);
        add_unit(1, 16'h0000, 1, texel_res(0, 32'h0, LANE_RGBA, 1, 0), NO_RES);
        add_write(REG_FORMAT, {29'd0, FMT_I8});
        add_unit(1, 16'h3c80, 1, texel_res(0, 32'h80, LANE_BYTE, 1, 0), NO_RES);
        add_write(REG_FORMAT, {29'd0, FMT_A4I4});
        add_unit(1, 16'hc37f, 1, texel_res(0, 32'h7f, LANE_BYTE, 1, 0), NO_RES);
        // unknown register leaves the walk alone
        add_write(REG_WIDTH, 32'd1024);
        add_write(REG_HEIGHT, 32'd1024);
        add_write(REG_FORMAT, {29'd0, FMT_ARGB8});
        add_unit(1, 16'h12ff, 1, texel_res(0, 32'h120000ff, LANE_AR, 1, 0), NO_RES);
        add_write(REG_SPARE, 32'hffffffff);
        add_unit(1, 16'h3456, 1, texel_res(1, 32'h34000056, LANE_AR, 1, 0), NO_RES);
        add_write(REG_FORMAT, {29'd0, FMT_NONE});
        add_unit(1, 16'hffff, 0, NO_RES, NO_RES);
        add_unit(1, 16'h0000, 0, NO_RES, NO_RES);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                wait_quiet();
                reg_write(script[i].reg_idx, script[i].data);
            end else begin
                send_unit(script[i]);
            end
        end

        sent = 0;
        paused = 1'b0;
        one = '0;
        one.kind = ROW_UNIT;
        while (sent < RANDOM_UNITS) begin
            f = ($urandom_range(0, 19) == 0) ? FMT_NONE : 3'($urandom_range(0, 6));
            w = pick_dim();
            h = pick_dim();
            wait_quiet();
            reg_write(REG_FORMAT, {29'($urandom), f});
            reg_write(REG_WIDTH, {21'($urandom), w});
            reg_write(REG_HEIGHT, {21'($urandom), h});
            tw = (f <= FMT_A4I4) ? 8 : 4;
            th = (f == FMT_I4) ? 8 : 4;
            cw = (w > MAX_DIM) ? MAX_DIM : int'(w);
            ch = (h > MAX_DIM) ? MAX_DIM : int'(h);
            tiles_x = (cw == 0) ? 1 : (cw + tw - 1) / tw;
            tiles_y = (ch == 0) ? 1 : (ch + th - 1) / th;
            units = tiles_x * tiles_y * tw * th / ((f == FMT_I4) ? 2 : 1);
            if (f == FMT_ARGB8) units = units * 2;
            if (f == FMT_NONE) begin
                n = $urandom_range(4, 16);
            end else if (units <= 300) begin
                n = units * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 20);
            end else begin
                n = $urandom_range(20, 150);
            end
            for (int k = 0; k < n; k++) begin
                // hold off mid-image until every pending result is out
                if (!paused && sent > 200 && k == n / 2) begin
                    wait_quiet();
                    paused = 1'b1;
                end
                calm = (sent >= 400 && sent < 750);
                one.src = 16'($urandom_range(0, 65535));
                send_unit(one);
                if (f != FMT_NONE) sent++;
            end
        end
        calm = 1'b0;
        wait_quiet();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/ttd_pkg.sv
rtl/core/ttd_walk.sv
rtl/core/ttd_decode.sv
rtl/core/ttd_outq.sv
rtl/core/tiled_texel_detiler.sv
rtl/core/ttd_check.sv
tb/sv/tb_tiled_texel_detiler.sv
